// File: hdl/rfa_pkg.sv
// Shared types and constants for the reduced fraction arithmetic core.
package rfa_pkg;

  localparam int ACTION_W = 2;
  localparam int NUM_W    = 33;
  localparam int DEN_W    = 32;

  localparam logic [ACTION_W-1:0] ACT_ADD = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_MUL = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CMP = 2'd2;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: hdl/rfa_if.sv
// Request and response channel interfaces of the reduced fraction arithmetic core.
interface rfa_req_if #(parameter int OPERAND_WIDTH = 16);
  import rfa_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [ACTION_W-1:0]      action;
  logic [OPERAND_WIDTH-1:0] a_num;
  logic [OPERAND_WIDTH-1:0] a_den;
  logic [OPERAND_WIDTH-1:0] b_num;
  logic [OPERAND_WIDTH-1:0] b_den;

  modport source(output valid, action, a_num, a_den, b_num, b_den, input ready);
  modport sink(input valid, action, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rfa_rsp_if;
  import rfa_pkg::*;
  logic             valid;
  logic             ready;
  logic [NUM_W-1:0] result_num;
  logic [DEN_W-1:0] result_den;
  logic             is_empty;
  logic             equal;
  logic             not_equal;

  modport source(output valid, result_num, result_den, is_empty, equal, not_equal,
                 input ready);
  modport sink(input valid, result_num, result_den, is_empty, equal, not_equal,
               output ready);
endinterface

// File: hdl/reduced_fraction_arithmetic_core.sv
// Reduced fraction arithmetic core: add, multiply and compare of two fractions.
// Compare, empty operand or unused action: go from idle straight to the result stage.
// Add/multiply: product states MUL0 to MUL2 (plus MUL3 for add) and a check on one multiplier,
// then binary gcd steps and bit-serial divides of numerator and denominator by the gcd.
// One request at a time: ready only in idle; the gcd subtractor and bit-serial divider set the pace.
// Reset: synchronous, clears sequencer and output valid; no memory to clear.
module reduced_fraction_arithmetic_core #(
  parameter int OPERAND_WIDTH = 16
) (
  input logic        clk,
  input logic        rst,
  rfa_req_if.sink    req,
  rfa_rsp_if.source  rsp
);
  import rfa_pkg::*;

  localparam int W  = OPERAND_WIDTH;
  localparam int NW = 2 * OPERAND_WIDTH + 1;
  localparam int DW = 2 * OPERAND_WIDTH;
  localparam int KW = $clog2(NW + 1);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_MUL0  = 12'b0000_0000_0010,
    S_MUL1  = 12'b0000_0000_0100,
    S_MUL2  = 12'b0000_0000_1000,
    S_MUL3  = 12'b0000_0001_0000,
    S_CHK   = 12'b0000_0010_0000,
    S_GCD   = 12'b0000_0100_0000,
    S_DIVN  = 12'b0000_1000_0000,
    S_WAITN = 12'b0001_0000_0000,
    S_DIVD  = 12'b0010_0000_0000,
    S_WAITD = 12'b0100_0000_0000,
    S_FIN   = 12'b1000_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  logic [ACTION_W-1:0] act;
  logic [W-1:0]        an;
  logic [W-1:0]        ad;
  logic [W-1:0]        bn;
  logic [W-1:0]        bd;
  logic [W-1:0]        mul_a;
  logic [W-1:0]        mul_b;
  logic [DW-1:0]       prod;
  logic [NW-1:0]       rn;
  logic [DW-1:0]       rd;
  logic [NW-1:0]       x;
  logic [NW-1:0]       y;
  logic [KW-1:0]       k;
  logic [NW-1:0]       g;
  logic                f_empty;
  logic                f_eq;
  logic                f_ne;

  logic                in_arith;
  logic                in_cmp;
  logic                in_empty;
  logic                accept;
  logic                fin_go;
  logic                x_gt;
  logic [NW-1:0]       sub;

  logic                div_start;
  logic [NW-1:0]       div_dividend;
  logic [NW-1:0]       div_quo;
  div_stat_t           div_stat;

  logic                rsp_valid;
  logic [NUM_W-1:0]    out_num;
  logic [DEN_W-1:0]    out_den;
  logic                out_empty;
  logic                out_eq;
  logic                out_ne;

  assign in_arith = (req.action == ACT_ADD) || (req.action == ACT_MUL);
  assign in_cmp   = req.action == ACT_CMP;
  assign in_empty = (req.a_den == '0) || (req.b_den == '0);
  assign req.ready = state == S_IDLE;
  assign accept   = req.valid && req.ready;
  assign fin_go   = (state == S_FIN) && (!rsp_valid || rsp.ready);

  always_comb begin
    mul_a = ad;
    mul_b = bd;
    if (state == S_MUL1) begin
      mul_a = an;
      mul_b = (act == ACT_ADD) ? bd : bn;
    end else if (state == S_MUL2) begin
      mul_a = ad;
      mul_b = bn;
    end
  end

  assign x_gt = x > y;
  assign sub  = x_gt ? (x - y) : (y - x);

  assign div_start    = (state == S_DIVN) || (state == S_DIVD);
  assign div_dividend = (state == S_DIVD) ? NW'(rd) : rn;

  rfa_div #(.WIDTH(NW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (g),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (in_arith && !in_empty) ? S_MUL0 : S_FIN;
        end
      end
      S_MUL0: state_next = S_MUL1;
      S_MUL1: state_next = S_MUL2;
      S_MUL2: state_next = (act == ACT_ADD) ? S_MUL3 : S_CHK;
      S_MUL3: state_next = S_CHK;
      S_CHK:  state_next = (rn == '0) ? S_FIN : S_GCD;
      S_GCD: begin
        if (x == y) begin
          state_next = S_DIVN;
        end
      end
      S_DIVN: state_next = S_WAITN;
      S_WAITN: begin
        if (div_stat.done) begin
          state_next = S_DIVD;
        end
      end
      S_DIVD: state_next = S_WAITD;
      S_WAITD: begin
        if (div_stat.done) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (fin_go) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (fin_go) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= DW'(mul_a) * DW'(mul_b);
    case (state)
      S_IDLE: begin
        if (accept) begin
          act     <= req.action;
          an      <= req.a_num;
          ad      <= req.a_den;
          bn      <= req.b_num;
          bd      <= req.b_den;
          rn      <= '0;
          rd      <= '0;
          f_empty <= in_arith && in_empty;
          f_eq    <= in_cmp && !in_empty && (req.a_num == req.b_num)
                     && (req.a_den == req.b_den);
          f_ne    <= in_cmp && !in_empty && !((req.a_num == req.b_num)
                     && (req.a_den == req.b_den));
        end
      end
      S_MUL1: rd <= prod;
      S_MUL2: rn <= NW'(prod);
      S_MUL3: rn <= rn + NW'(prod);
      S_CHK: begin
        x <= rn;
        y <= NW'(rd);
        k <= '0;
      end
      S_GCD: begin
        if (x == y) begin
          g <= x << k;
        end else if (!x[0] && !y[0]) begin
          x <= x >> 1;
          y <= y >> 1;
          k <= k + 1'b1;
        end else if (!x[0]) begin
          x <= x >> 1;
        end else if (!y[0]) begin
          y <= y >> 1;
        end else if (x_gt) begin
          x <= sub >> 1;
        end else begin
          y <= sub >> 1;
        end
      end
      S_WAITN: begin
        if (div_stat.done) begin
          rn <= div_quo;
        end
      end
      S_WAITD: begin
        if (div_stat.done) begin
          rd <= DW'(div_quo);
        end
      end
      S_FIN: begin
        if (fin_go) begin
          out_num   <= NUM_W'(rn);
          out_den   <= DEN_W'(rd);
          out_empty <= f_empty;
          out_eq    <= f_eq;
          out_ne    <= f_ne;
        end
      end
      default: begin
      end
    endcase
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.result_num = out_num;
  assign rsp.result_den = out_den;
  assign rsp.is_empty   = out_empty;
  assign rsp.equal      = out_eq;
  assign rsp.not_equal  = out_ne;

`ifndef SYNTHESIS
  a_gcd_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_GCD |-> (x != '0) && (y != '0))
    else $error("gcd operand reached zero");

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(out_eq && out_ne) && !(out_empty && (out_eq || out_ne)))
    else $error("conflicting result flags");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && out_empty |-> (out_num == '0) && (out_den == '0))
    else $error("empty result with non-zero fields");

  a_div_done_waiting: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == S_WAITN) || (state == S_WAITD))
    else $error("divider finished outside a wait state");
`endif

endmodule

// File: hdl/rfa_div.sv
// Restoring divider, one quotient bit per cycle.
module rfa_div #(
  parameter int WIDTH = 33
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [WIDTH-1:0]   dividend,
  input  logic [WIDTH-1:0]   divisor,
  output logic [WIDTH-1:0]   quotient,
  output rfa_pkg::div_stat_t stat
);
  import rfa_pkg::*;

  localparam int CW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] quo;
  logic [WIDTH-1:0] rem;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic             done;
  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   diff;
  logic             fits;

  assign trial = {rem, quo[WIDTH-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      cnt <= CW'(WIDTH);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (fits) begin
        rem <= diff[WIDTH-1:0];
        quo <= {quo[WIDTH-2:0], 1'b1};
      end else begin
        rem <= trial[WIDTH-1:0];
        quo <= {quo[WIDTH-2:0], 1'b0};
      end
    end
  end

  assign quotient  = quo;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule
